### sv/sha1md_pkg.sv
package sha1md_pkg;

    localparam int WORD_W  = 32;
    localparam int SLOTS   = 16;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int NUM_H   = 5;
    localparam int IDX_W   = 3;
    localparam int ROUNDS  = 80;
    localparam int RND_W   = 7;
    localparam int LEN_W   = 64;
    localparam int BCNT_W  = 3;

    localparam logic [SLOT_W-1:0] SLOT_LEN_HI = 4'd14;
    localparam logic [SLOT_W-1:0] SLOT_LAST   = 4'd15;
    localparam logic [IDX_W-1:0]  IDX_LAST    = 3'(NUM_H - 1);
    localparam logic [RND_W-1:0]  RND_LAST    = 7'(ROUNDS - 1);
    localparam logic [BCNT_W-1:0] BYTES_FULL  = 3'd4;

    localparam logic [WORD_W-1:0] K_00_19 = 32'h5A82_7999;
    localparam logic [WORD_W-1:0] K_20_39 = 32'h6ED9_EBA1;
    localparam logic [WORD_W-1:0] K_40_59 = 32'h8F1B_BCDC;
    localparam logic [WORD_W-1:0] K_60_79 = 32'hCA62_C1D6;

    localparam logic [7:0]        MARKER_BYTE = 8'h80;
    localparam logic [WORD_W-1:0] MARKER_WORD = 32'h8000_0000;

    typedef logic [WORD_W-1:0]             word_t;
    typedef logic [SLOT_W-1:0]             slot_t;
    typedef logic [NUM_H-1:0][WORD_W-1:0]  chain_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_WAIT,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_PRIME,
        C_ROUND,
        C_ADD
    } core_state_t;

    typedef struct packed {
        logic  start;
        logic  wr_en;
        slot_t wr_addr;
        word_t wr_data;
        logic  chain_init;
    } core_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    function automatic word_t iv_word(input logic [IDX_W-1:0] i);
        word_t w;
        case (i)
            3'd0:    w = 32'h6745_2301;
            3'd1:    w = 32'hEFCD_AB89;
            3'd2:    w = 32'h98BA_DCFE;
            3'd3:    w = 32'h1032_5476;
            default: w = 32'hC3D2_E1F0;
        endcase
        return w;
    endfunction

    function automatic chain_t iv_chain();
        chain_t c;
        for (int i = 0; i < NUM_H; i++)
        begin
            c[i] = iv_word(IDX_W'(i));
        end
        return c;
    endfunction

endpackage

### sv/sha1md_msg_if.sv
interface sha1md_msg_if;
    logic                         valid;
    logic                         ready;
    logic [31:0]                  data_word;
    logic [2:0]                   byte_count;
    logic                         last_word;

    modport source (output valid, output data_word, output byte_count, output last_word,
                    input ready);
    modport sink (input valid, input data_word, input byte_count, input last_word,
                  output ready);
endinterface

### sv/sha1md_dgst_if.sv
interface sha1md_dgst_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_done;

    modport source (output valid, output digest_word, output word_index, output digest_done,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input digest_done,
                  output ready);
endinterface

### sv/sha1_message_digest_top.sv
// Channel  Role    Beat contents                              Accepted when
// -------  ------  -----------------------------------------  -----------------------
// msg      sink    data_word, byte_count, last_word           msg.valid & msg.ready
// dgst     source  digest_word, word_index, digest_done       dgst.valid & dgst.ready
//
// A message beat is taken while the block is idle. Each full 64-byte block
// then runs in the compression core: one operand fetch, 80 rounds, one
// feed-forward. The round loop is bounded by one round per cycle through the
// schedule memories. After the last beat, padding writes one word per cycle,
// one or two compressions follow, and the five digest beats leave one per
// cycle from an output register while dgst.ready is high.
// Reset loads the initial vector and clears the byte and slot counts; the schedule
// memory is not cleared. A stalled dgst holds the current digest beat; msg.ready is
// low while padding, compressing or emitting.
module sha1_message_digest_top (
    input  logic          clk,
    input  logic          rst_n,
    sha1md_msg_if.sink    msg,
    sha1md_dgst_if.source dgst
);

    // command and status between the sequencer and the compression core
    sha1md_pkg::core_cmd_t  cmd;
    sha1md_pkg::core_stat_t stat;
    sha1md_pkg::chain_t     chain;

    // Sequencer: collect message beats into the schedule memory, append the end
    // marker, zero fill and bit length, and drive the digest beats out.
    sha1md_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg),
        .dgst  (dgst),
        .stat  (stat),
        .chain (chain),
        .cmd   (cmd)
    );

    // Compression core: owns the two copies of the 16-word schedule memory, runs
    // the rounds with a read-modify-write of the schedule, and holds the chain.
    sha1md_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .chain (chain)
    );

endmodule

### sv/sha1md_wram.sv
module sha1md_wram (
    input  logic                clk,
    input  logic                wr_en,
    input  sha1md_pkg::slot_t   wr_addr,
    input  sha1md_pkg::word_t   wr_data,
    input  sha1md_pkg::slot_t   rd_addr0,
    input  sha1md_pkg::slot_t   rd_addr1,
    output sha1md_pkg::word_t   rd_data0,
    output sha1md_pkg::word_t   rd_data1
);

    sha1md_pkg::word_t mem [sha1md_pkg::SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data0 <= mem[rd_addr0];
        rd_data1 <= mem[rd_addr1];
    end

endmodule

### sv/sha1md_core.sv
module sha1md_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sha1md_pkg::core_cmd_t   cmd,
    output sha1md_pkg::core_stat_t  stat,
    output sha1md_pkg::chain_t      chain
);

    sha1md_pkg::core_state_t        state_reg, state_next;
    logic [sha1md_pkg::RND_W-1:0]   rnd_reg, rnd_next;
    sha1md_pkg::chain_t             vars_reg, vars_next;
    sha1md_pkg::chain_t             chain_reg;

    sha1md_pkg::slot_t iss_slot;
    sha1md_pkg::slot_t ra0, ra1, rb0, rb1;
    sha1md_pkg::word_t da0, da1, db0, db1;
    sha1md_pkg::word_t w_sched, w_cur, f_val, k_val, temp;
    sha1md_pkg::word_t a, b, c, d, e;
    logic              sched_wr;
    logic              mem_wen;
    sha1md_pkg::slot_t mem_waddr;
    sha1md_pkg::word_t mem_wdata;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha1md_pkg::C_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = sha1md_pkg::C_PRIME;
                end
            end
            sha1md_pkg::C_PRIME: state_next = sha1md_pkg::C_ROUND;
            sha1md_pkg::C_ROUND:
            begin
                if (rnd_reg == sha1md_pkg::RND_LAST)
                begin
                    state_next = sha1md_pkg::C_ADD;
                end
            end
            sha1md_pkg::C_ADD:   state_next = sha1md_pkg::C_IDLE;
            default:             state_next = sha1md_pkg::C_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        stat.busy = (state_reg != sha1md_pkg::C_IDLE);
        stat.done = (state_reg == sha1md_pkg::C_ADD);
        sched_wr  = (state_reg == sha1md_pkg::C_ROUND) && (rnd_reg >= 7'd16);
    end

    // fetch operands one round ahead: W[t-3], W[t-8], W[t-14], W[t-16]
    assign iss_slot = (state_reg == sha1md_pkg::C_PRIME) ? '0 : rnd_reg[3:0] + 4'd1;
    assign ra0      = iss_slot - 4'd3;
    assign ra1      = iss_slot - 4'd8;
    assign rb0      = iss_slot - 4'd14;
    assign rb1      = iss_slot;

    assign mem_wen   = sched_wr || cmd.wr_en;
    assign mem_waddr = sched_wr ? rnd_reg[3:0] : cmd.wr_addr;
    assign mem_wdata = sched_wr ? w_sched : cmd.wr_data;

    sha1md_wram u_wram_a (
        .clk      (clk),
        .wr_en    (mem_wen),
        .wr_addr  (mem_waddr),
        .wr_data  (mem_wdata),
        .rd_addr0 (ra0),
        .rd_addr1 (ra1),
        .rd_data0 (da0),
        .rd_data1 (da1)
    );

    sha1md_wram u_wram_b (
        .clk      (clk),
        .wr_en    (mem_wen),
        .wr_addr  (mem_waddr),
        .wr_data  (mem_wdata),
        .rd_addr0 (rb0),
        .rd_addr1 (rb1),
        .rd_data0 (db0),
        .rd_data1 (db1)
    );

    assign a = vars_reg[0];
    assign b = vars_reg[1];
    assign c = vars_reg[2];
    assign d = vars_reg[3];
    assign e = vars_reg[4];

    always_comb
    begin
        sha1md_pkg::word_t x;
        x       = da0 ^ da1 ^ db0 ^ db1;
        w_sched = {x[30:0], x[31]};
        w_cur   = (rnd_reg < 7'd16) ? db1 : w_sched;

        if (rnd_reg < 7'd20)
        begin
            f_val = (b & c) | (~b & d);
            k_val = sha1md_pkg::K_00_19;
        end
        else if (rnd_reg < 7'd40)
        begin
            f_val = b ^ c ^ d;
            k_val = sha1md_pkg::K_20_39;
        end
        else if (rnd_reg < 7'd60)
        begin
            f_val = (b & c) | (b & d) | (c & d);
            k_val = sha1md_pkg::K_40_59;
        end
        else
        begin
            f_val = b ^ c ^ d;
            k_val = sha1md_pkg::K_60_79;
        end
        temp = {a[26:0], a[31:27]} + f_val + e + w_cur + k_val;
    end

    always_comb
    begin
        rnd_next  = rnd_reg;
        vars_next = vars_reg;
        case (state_reg)
            sha1md_pkg::C_PRIME:
            begin
                rnd_next  = '0;
                vars_next = chain_reg;
            end
            sha1md_pkg::C_ROUND:
            begin
                rnd_next     = rnd_reg + 7'd1;
                vars_next[0] = temp;
                vars_next[1] = a;
                vars_next[2] = {b[1:0], b[31:2]};
                vars_next[3] = c;
                vars_next[4] = d;
            end
            default:
            begin
                rnd_next  = rnd_reg;
                vars_next = vars_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha1md_pkg::C_IDLE;
            rnd_reg   <= '0;
            vars_reg  <= '0;
            chain_reg <= sha1md_pkg::iv_chain();
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            vars_reg  <= vars_next;
            if (cmd.chain_init)
            begin
                chain_reg <= sha1md_pkg::iv_chain();
            end
            else if (state_reg == sha1md_pkg::C_ADD)
            begin
                for (int i = 0; i < sha1md_pkg::NUM_H; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + vars_reg[i];
                end
            end
        end
    end

    assign chain = chain_reg;

`ifndef ASSERT_OFF
    a_no_host_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (state_reg == sha1md_pkg::C_IDLE))
        else $error("schedule memory written from outside during compression");

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> (state_reg == sha1md_pkg::C_IDLE) && !cmd.chain_init)
        else $error("compression started while busy or during chain reload");

    a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha1md_pkg::C_ADD) |-> ($past(rnd_reg) == sha1md_pkg::RND_LAST))
        else $error("feed-forward reached without all rounds");
`endif

endmodule

### sv/sha1md_ctrl.sv
module sha1md_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    sha1md_msg_if.sink              msg,
    sha1md_dgst_if.source           dgst,
    input  sha1md_pkg::core_stat_t  stat,
    input  sha1md_pkg::chain_t      chain,
    output sha1md_pkg::core_cmd_t   cmd
);

    sha1md_pkg::ctrl_state_t        state_reg, state_next;
    sha1md_pkg::slot_t              slot_reg, slot_next;
    logic [sha1md_pkg::LEN_W-1:0]   bytes_reg, bytes_next;
    logic                           marker_reg, marker_next;
    logic                           len_hi_reg, len_hi_next;
    logic                           final_reg, final_next;
    logic                           finish_reg, finish_next;
    logic [sha1md_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                           out_valid_reg, out_valid_next;
    sha1md_pkg::word_t              out_word_reg;
    logic [sha1md_pkg::IDX_W-1:0]   out_idx_reg;
    logic                           out_done_reg;

    logic                           acc;
    logic                           wr_en;
    sha1md_pkg::word_t              wr_data;
    logic [sha1md_pkg::BCNT_W-1:0]  n_bytes;
    logic [sha1md_pkg::BCNT_W-1:0]  add_bytes;
    logic                           emit_load;
    logic                           emit_end;
    sha1md_pkg::word_t              len_hi;
    sha1md_pkg::word_t              len_lo;

    assign n_bytes   = (msg.byte_count > sha1md_pkg::BYTES_FULL) ? sha1md_pkg::BYTES_FULL
                                                                 : msg.byte_count;
    assign add_bytes = msg.last_word ? n_bytes : sha1md_pkg::BYTES_FULL;
    assign len_hi    = bytes_reg[60:29];
    assign len_lo    = {bytes_reg[28:0], 3'b000};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha1md_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    if (slot_reg == sha1md_pkg::SLOT_LAST)
                    begin
                        state_next = sha1md_pkg::ST_WAIT;
                    end
                    else if (msg.last_word)
                    begin
                        state_next = sha1md_pkg::ST_PAD;
                    end
                end
            end
            sha1md_pkg::ST_PAD:
            begin
                if (slot_reg == sha1md_pkg::SLOT_LAST)
                begin
                    state_next = sha1md_pkg::ST_WAIT;
                end
            end
            sha1md_pkg::ST_WAIT:
            begin
                if (stat.done)
                begin
                    if (final_reg)
                    begin
                        state_next = sha1md_pkg::ST_EMIT;
                    end
                    else if (finish_reg)
                    begin
                        state_next = sha1md_pkg::ST_PAD;
                    end
                    else
                    begin
                        state_next = sha1md_pkg::ST_IDLE;
                    end
                end
            end
            sha1md_pkg::ST_EMIT:
            begin
                if (emit_end)
                begin
                    state_next = sha1md_pkg::ST_IDLE;
                end
            end
            default: state_next = sha1md_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        msg.ready = (state_reg == sha1md_pkg::ST_IDLE);
        acc       = msg.valid && (state_reg == sha1md_pkg::ST_IDLE);
        wr_en     = acc || (state_reg == sha1md_pkg::ST_PAD);
        emit_load = (state_reg == sha1md_pkg::ST_EMIT) && (!out_valid_reg || dgst.ready);
        emit_end  = emit_load && (idx_reg == sha1md_pkg::IDX_LAST);

        wr_data = '0;
        case (state_reg)
            sha1md_pkg::ST_IDLE:
            begin
                if (!msg.last_word)
                begin
                    wr_data = msg.data_word;
                end
                else
                begin
                    case (n_bytes)
                        3'd0:    wr_data = sha1md_pkg::MARKER_WORD;
                        3'd1:    wr_data = {msg.data_word[31:24], sha1md_pkg::MARKER_BYTE,
                                            16'h0000};
                        3'd2:    wr_data = {msg.data_word[31:16], sha1md_pkg::MARKER_BYTE,
                                            8'h00};
                        3'd3:    wr_data = {msg.data_word[31:8], sha1md_pkg::MARKER_BYTE};
                        default: wr_data = msg.data_word;
                    endcase
                end
            end
            sha1md_pkg::ST_PAD:
            begin
                if (marker_reg)
                begin
                    wr_data = sha1md_pkg::MARKER_WORD;
                end
                else if (slot_reg == sha1md_pkg::SLOT_LEN_HI)
                begin
                    wr_data = len_hi;
                end
                else if ((slot_reg == sha1md_pkg::SLOT_LAST) && len_hi_reg)
                begin
                    wr_data = len_lo;
                end
            end
            default: wr_data = '0;
        endcase

        cmd.wr_en      = wr_en;
        cmd.wr_addr    = slot_reg;
        cmd.wr_data    = wr_data;
        cmd.start      = wr_en && (slot_reg == sha1md_pkg::SLOT_LAST);
        cmd.chain_init = emit_end;
    end

    // counters and padding flags
    always_comb
    begin
        slot_next   = wr_en ? slot_reg + 4'd1 : slot_reg;
        bytes_next  = bytes_reg;
        marker_next = marker_reg;
        len_hi_next = len_hi_reg;
        final_next  = final_reg;
        finish_next = finish_reg;
        idx_next    = idx_reg;

        if (acc)
        begin
            bytes_next  = bytes_reg + {61'd0, add_bytes};
            marker_next = msg.last_word && (n_bytes == sha1md_pkg::BYTES_FULL);
            finish_next = msg.last_word;
        end
        if (state_reg == sha1md_pkg::ST_PAD)
        begin
            marker_next = 1'b0;
            if (!marker_reg && (slot_reg == sha1md_pkg::SLOT_LEN_HI))
            begin
                len_hi_next = 1'b1;
            end
            if (!marker_reg && len_hi_reg && (slot_reg == sha1md_pkg::SLOT_LAST))
            begin
                final_next = 1'b1;
            end
        end
        if (emit_load)
        begin
            idx_next = idx_reg + 3'd1;
        end
        if (emit_end)
        begin
            bytes_next  = '0;
            len_hi_next = 1'b0;
            final_next  = 1'b0;
            finish_next = 1'b0;
            idx_next    = '0;
        end

        out_valid_next = emit_load ? 1'b1 : (dgst.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha1md_pkg::ST_IDLE;
            slot_reg      <= '0;
            bytes_reg     <= '0;
            marker_reg    <= 1'b0;
            len_hi_reg    <= 1'b0;
            final_reg     <= 1'b0;
            finish_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            bytes_reg     <= bytes_next;
            marker_reg    <= marker_next;
            len_hi_reg    <= len_hi_next;
            final_reg     <= final_next;
            finish_reg    <= finish_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_word_reg <= chain[idx_reg];
            out_idx_reg  <= idx_reg;
            out_done_reg <= (idx_reg == sha1md_pkg::IDX_LAST);
        end
    end

    assign dgst.valid       = out_valid_reg;
    assign dgst.digest_word = out_word_reg;
    assign dgst.word_index  = out_idx_reg;
    assign dgst.digest_done = out_done_reg;

`ifndef ASSERT_OFF
    a_ready_core_idle: assert property (@(posedge clk) disable iff (!rst_n)
        msg.ready |-> !stat.busy)
        else $error("input taken while compression runs");

    a_start_on_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (slot_reg == '0) && (state_reg == sha1md_pkg::ST_WAIT))
        else $error("compression started without a full block");

    a_clear_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.chain_init |=> (slot_reg == '0) && (bytes_reg == '0) && !final_reg)
        else $error("message state not cleared after digest");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // Beat formats of the two channels
    typedef struct packed {
        sha1md_pkg::word_t                 data;
        logic [sha1md_pkg::BCNT_W-1:0]     count;
        logic                              last;
    } msg_beat_t;

    typedef struct packed {
        sha1md_pkg::word_t                 word;
        logic [sha1md_pkg::IDX_W-1:0]      index;
        logic                              done;
    } digest_beat_t;

    // Pacing of the two channels, one setting per phase of the run
    typedef enum int {
        PH_STEADY,
        PH_SRC_GAPS,
        PH_SINK_STALLS,
        PH_BOTH
    } pace_t;

    localparam int  CLK_HALF     = 2;
    localparam int  QUIET_LIMIT  = 3000;
    localparam int  DRAIN_CYCLES = 300;
    localparam int  PHASE_BEATS  = 36;
    localparam int  MAX_REPORTS  = 10;

    localparam sha1md_pkg::word_t HASH_IV [sha1md_pkg::NUM_H] =
        '{32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0};
    localparam sha1md_pkg::word_t ROUND_K [4] =
        '{32'h5A82_7999, 32'h6ED9_EBA1, 32'h8F1B_BCDC, 32'hCA62_C1D6};
    localparam sha1md_pkg::word_t PAD_MARKER  = 32'h8000_0000;
    localparam int                FULL_BYTES  = 4;

    logic clk;
    logic rst_n;

    sha1md_msg_if  msg_ch ();
    sha1md_dgst_if dgst_ch ();

    sha1_message_digest_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_ch),
        .dgst  (dgst_ch)
    );

    // Message beats waiting to be driven, digest beats waiting to come out
    msg_beat_t    pending_beats[$];
    digest_beat_t digest_due[$];

    // Our own copy of the hash state
    sha1md_pkg::word_t  chain_h [sha1md_pkg::NUM_H];
    sha1md_pkg::word_t  sched [sha1md_pkg::SLOTS];
    sha1md_pkg::slot_t  fill_slot;
    logic [63:0]        byte_total;

    pace_t        pace = PH_STEADY;
    int           failures = 0;
    int           reports = 0;
    int           quiet_cycles = 0;
    msg_beat_t    next_beat;
    digest_beat_t seen, want;

    // ------------------------------------------------------------------
    // Clock and reset: hold reset low at the start, then release it for good
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Digest predictor
    // ------------------------------------------------------------------
    function automatic sha1md_pkg::word_t rotl(input sha1md_pkg::word_t x, input int n);
        return (x << n) | (x >> (sha1md_pkg::WORD_W - n));
    endfunction

    // Run the 80 rounds over the current block and fold them into the chain.
    task automatic sha1_compress();
        sha1md_pkg::word_t a, b, c, d, e, w, f, k, t_new;
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int t = 0; t < sha1md_pkg::ROUNDS; t++)
        begin
            if (t < sha1md_pkg::SLOTS)
            begin
                w = sched[t];
            end
            else
            begin
                // expand the schedule in place, 16-word circular window
                w = rotl(sched[(t - 3) & 15] ^ sched[(t - 8) & 15] ^
                         sched[(t - 14) & 15] ^ sched[t & 15], 1);
                sched[t & 15] = w;
            end
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = ROUND_K[0];
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = ROUND_K[1];
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = ROUND_K[2];
            end
            else
            begin
                f = b ^ c ^ d;
                k = ROUND_K[3];
            end
            t_new = rotl(a, 5) + f + e + w + k;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t_new;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endtask

    // Store one word in the block; compress once the block is full.
    task automatic block_word(input sha1md_pkg::word_t w);
        sched[fill_slot] = w;
        fill_slot = fill_slot + 1'b1;
        if (fill_slot == '0)
        begin
            sha1_compress();
        end
    endtask

    // Absorb one accepted message beat; on the last beat pad the message
    // and queue the five digest words it must produce.
    task automatic sha1_absorb(input msg_beat_t beat);
        int                 n;
        sha1md_pkg::word_t  keep;
        logic [63:0]        bits;
        if (!beat.last)
        begin
            // byte_count means nothing before the final word
            byte_total += FULL_BYTES;
            block_word(beat.data);
        end
        else
        begin
            // counts above four saturate
            n = (beat.count > FULL_BYTES) ? FULL_BYTES : int'(beat.count);
            byte_total += n;
            if (n == FULL_BYTES)
            begin
                block_word(beat.data);
                block_word(PAD_MARKER);
            end
            else if (n == 0)
            begin
                block_word(PAD_MARKER);
            end
            else
            begin
                // drop the bytes past the count, then place the marker
                keep = 32'hFFFF_FFFF << (32 - 8 * n);
                block_word((beat.data & keep) | (32'h80 << (24 - 8 * n)));
            end
            // no room for the length: zero out this block and start another
            if (fill_slot == sha1md_pkg::SLOT_LAST)
            begin
                while (fill_slot != '0)
                begin
                    block_word('0);
                end
            end
            while (fill_slot < sha1md_pkg::SLOT_LEN_HI)
            begin
                block_word('0);
            end
            bits = byte_total << 3;
            block_word(bits[63:32]);
            block_word(bits[31:0]);
            for (int i = 0; i < sha1md_pkg::NUM_H; i++)
            begin
                digest_due.push_back('{chain_h[i], sha1md_pkg::IDX_W'(i),
                                       (i == sha1md_pkg::NUM_H - 1)});
            end
            chain_h    = HASH_IV;
            byte_total = '0;
            fill_slot  = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // Pacing
    // ------------------------------------------------------------------
    function automatic bit sender_rests();
        case (pace)
            PH_SRC_GAPS: return $urandom_range(99) < 53;
            PH_BOTH:     return $urandom_range(99) < 11;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (pace)
            PH_SINK_STALLS: return $urandom_range(99) < 53;
            PH_BOTH:        return $urandom_range(99) < 11;
            default:        return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: on each edge, absorb the beat just accepted, then present
    // the next pending beat or drop valid for a gap. Hold the beat while
    // ready is low.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_ch.valid      <= 1'b0;
            msg_ch.data_word  <= '0;
            msg_ch.byte_count <= '0;
            msg_ch.last_word  <= 1'b0;
            chain_h            = HASH_IV;
            byte_total         = '0;
            fill_slot          = '0;
        end
        else
        begin
            if (msg_ch.valid && msg_ch.ready)
            begin
                sha1_absorb('{msg_ch.data_word, msg_ch.byte_count, msg_ch.last_word});
            end
            if (!msg_ch.valid || msg_ch.ready)
            begin
                if (pending_beats.size() != 0 && !sender_rests())
                begin
                    next_beat          = pending_beats.pop_front();
                    msg_ch.valid      <= 1'b1;
                    msg_ch.data_word  <= next_beat.data;
                    msg_ch.byte_count <= next_beat.count;
                    msg_ch.last_word  <= next_beat.last;
                end
                else
                begin
                    msg_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted digest beat against the oldest
    // expectation, field by field, and stall the receiver at random.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dgst_ch.ready <= 1'b0;
        end
        else
        begin
            if (dgst_ch.valid && dgst_ch.ready)
            begin
                seen = '{dgst_ch.digest_word, dgst_ch.word_index, dgst_ch.digest_done};
                if (digest_due.size() == 0)
                begin
                    failures++;
                    reports++;
                    if (reports <= MAX_REPORTS)
                    begin
                        $display("%0t: digest beat with none expected: word %h index %0d done %b",
                                 $realtime, seen.word, seen.index, seen.done);
                    end
                end
                else
                begin
                    want = digest_due.pop_front();
                    if (seen.word !== want.word || seen.index !== want.index ||
                        seen.done !== want.done)
                    begin
                        failures++;
                        reports++;
                        if (reports <= MAX_REPORTS)
                        begin
                            $display("%0t: digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                                     $realtime, want.word, want.index, want.done,
                                     seen.word, seen.index, seen.done);
                        end
                    end
                end
            end
            dgst_ch.ready <= !receiver_stalls();
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles in which neither channel moves a beat
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && !(msg_ch.valid && msg_ch.ready) && !(dgst_ch.valid && dgst_ch.ready))
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        else
        begin
            quiet_cycles <= 0;
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    // Mostly random words, with all-zero and all-one words mixed in.
    function automatic sha1md_pkg::word_t pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Queue one message: some full words, then a final word with the given count.
    task automatic queue_message(input int words,
                                 input logic [sha1md_pkg::BCNT_W-1:0] tail_count);
        for (int i = 0; i < words; i++)
        begin
            pending_beats.push_back('{pick_word(), sha1md_pkg::BCNT_W'($urandom_range(7)),
                                      1'b0});
        end
        pending_beats.push_back('{pick_word(), tail_count, 1'b1});
    endtask

    initial
    begin
        int queued;
        int words;

        // empty message
        pending_beats.push_back('{32'h0000_0000, 3'd0, 1'b1});
        // "abc", with a junk byte past the count that must be dropped
        pending_beats.push_back('{32'h6162_63FF, 3'd3, 1'b1});
        // single partial and full final words
        pending_beats.push_back('{32'hFFFF_FFFF, 3'd1, 1'b1});
        pending_beats.push_back('{32'hFFFF_FFFF, 3'd2, 1'b1});
        pending_beats.push_back('{32'hFFFF_FFFF, sha1md_pkg::BYTES_FULL, 1'b1});
        // counts above four saturate to a full word
        pending_beats.push_back('{32'hFFFF_FFFF, 3'd5, 1'b1});
        pending_beats.push_back('{32'h0000_0000, 3'd6, 1'b1});
        pending_beats.push_back('{32'h1234_5678, 3'd7, 1'b1});
        // 56-byte message: the marker lands in slot 14, so the length
        // spills into a second block; counts on full words are ignored
        for (int i = 0; i < 14; i++)
        begin
            pending_beats.push_back('{(i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000,
                                      sha1md_pkg::BCNT_W'(i % 8), 1'b0});
        end
        pending_beats.push_back('{32'hFFFF_FFFF, 3'd0, 1'b1});

        @(posedge rst_n);

        for (int p = PH_STEADY; p <= PH_BOTH; p++)
        begin
            pace   = pace_t'(p);
            queued = 0;
            while (queued < PHASE_BEATS)
            begin
                // weight lengths toward the one- and two-block padding boundary
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: words = $urandom_range(0, 20);
                    6, 7:             words = $urandom_range(12, 16);
                    default:          words = $urandom_range(17, 40);
                endcase
                queue_message(words, sha1md_pkg::BCNT_W'($urandom_range(7)));
                queued += words + 1;
            end
            // let the phase drain before changing the pacing
            while (pending_beats.size() != 0 || msg_ch.valid || digest_due.size() != 0)
            begin
                @(posedge clk);
            end
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0 && digest_due.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
